// ===== hdl/fasta_fastq_record_deframer_top_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Each macro expects clk and rst to be visible where it is used.
`ifndef FASTA_FASTQ_RECORD_DEFRAMER_TOP_MACROS_SVH
`define FASTA_FASTQ_RECORD_DEFRAMER_TOP_MACROS_SVH

// Check that a condition holds at every edge outside reset
`define FQD_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("fqd assertion failed");

// Check that an antecedent implies a consequent in the same cycle
`define FQD_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fqd assertion failed");

// Check a property that also has to hold across the reset release
`define FQD_ASSERT_FELL(lbl, sig, cons) \
  lbl: assert property (@(posedge clk) $fell(sig) |-> (cons)) \
    else $error("fqd assertion failed");

`endif

// ===== hdl/fqd_pkg.sv =====
// Package for the FASTA/FASTQ record deframer: codes, result type, constants.
// No dependencies; used by fqd_parser and fasta_fastq_record_deframer_top.
package fqd_pkg;

  localparam int LENGTH_BITS = 32;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  // Result queue depth and pointer width
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Characters of interest
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_LF   = 8'h0A;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_HEADER  = 3'd1,
    PH_SEQ     = 3'd2,
    PH_PLUS    = 3'd3,
    PH_QUAL    = 3'd4,
    PH_NEXTHDR = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    K_HDR  = 3'd0,
    K_BASE = 3'd1,
    K_QUAL = 3'd2,
    K_END  = 3'd3,
    K_ERR  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    E_NONE     = 2'd0,
    E_FORMAT   = 2'd1,
    E_BADHDR   = 2'd2,
    E_QUAL_LEN = 2'd3
  } err_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    err_t       err;
    logic       fastq;
    logic       last;
  } result_t;

  // Results produced by one accepted item
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } result_pair_t;

endpackage

// ===== hdl/fqd_parser.sv =====
// Parser state and per-byte classification for the record deframer.
// Depends on fqd_pkg; produces up to two results per accepted item.
module fqd_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_take,
  input  logic [7:0]         in_byte,
  input  logic               end_of_stream,
  output fqd_pkg::result_pair_t res
);
  import fqd_pkg::*;

  phase_t                 phase, phase_next;
  logic                   fastq, fastq_next;
  logic                   line_start, line_start_next;
  logic [LENGTH_BITS-1:0] seq_len, seq_len_next;
  logic [LENGTH_BITS-1:0] qual_len, qual_len_next;
  logic                   stuck, stuck_next;

  logic [LENGTH_BITS-1:0] seq_inc, qual_inc;
  logic                   lens_equal;
  kind_t                  k0, k1;
  logic [7:0]             b0;
  err_t                   e0;
  logic [1:0]             n;

  assign seq_inc    = (seq_len == LEN_MAX) ? seq_len : seq_len + 1'b1;
  assign qual_inc   = (qual_len == LEN_MAX) ? qual_len : qual_len + 1'b1;
  assign lens_equal = (qual_len == seq_len);

  // Next state and results for the incoming byte
  always_comb begin
    phase_next      = phase;
    fastq_next      = fastq;
    line_start_next = line_start;
    seq_len_next    = seq_len;
    qual_len_next   = qual_len;
    stuck_next      = stuck;
    n  = 2'd0;
    k0 = K_HDR;
    b0 = 8'h00;
    e0 = E_NONE;
    k1 = K_HDR;
    if (!stuck && phase != PH_DONE) begin
      if (end_of_stream) begin
        phase_next = PH_DONE;
        case (phase)
          PH_START: begin
            n = 2'd1; k0 = K_ERR; e0 = E_FORMAT; stuck_next = 1'b1;
          end
          PH_HEADER, PH_SEQ, PH_PLUS, PH_QUAL: begin
            n  = 2'd1;
            k0 = K_END;
            if (fastq && !lens_equal) begin
              k0 = K_ERR; e0 = E_QUAL_LEN; stuck_next = 1'b1;
            end
          end
          default: ;
        endcase
      end else begin
        case (phase)
          PH_START: begin
            n = 2'd1;
            if (in_byte == CH_GT || in_byte == CH_AT) begin
              fastq_next      = (in_byte == CH_AT);
              phase_next      = PH_HEADER;
              seq_len_next    = '0;
              qual_len_next   = '0;
              line_start_next = 1'b0;
              k0 = K_HDR; b0 = in_byte;
            end else begin
              k0 = K_ERR; e0 = E_FORMAT; stuck_next = 1'b1;
            end
          end
          PH_HEADER: begin
            if (in_byte == CH_LF) begin
              phase_next = PH_SEQ; line_start_next = 1'b1;
            end else begin
              n = 2'd1; k0 = K_HDR; b0 = in_byte;
            end
          end
          PH_SEQ: begin
            if (in_byte == CH_LF) begin
              line_start_next = 1'b1;
            end else if (line_start && !fastq && in_byte == CH_GT) begin
              // FASTA record boundary: close this record, open the next
              n  = 2'd2;
              k0 = K_END;
              k1 = K_HDR;
              phase_next      = PH_HEADER;
              seq_len_next    = '0;
              qual_len_next   = '0;
              line_start_next = 1'b0;
            end else if (line_start && fastq && in_byte == CH_PLUS) begin
              phase_next = PH_PLUS; line_start_next = 1'b0;
            end else begin
              seq_len_next    = seq_inc;
              line_start_next = 1'b0;
              n = 2'd1; k0 = K_BASE; b0 = in_byte;
            end
          end
          PH_PLUS: begin
            if (in_byte == CH_LF) begin
              if (seq_len == '0) begin
                phase_next = PH_NEXTHDR; n = 2'd1; k0 = K_END;
              end else begin
                phase_next = PH_QUAL; line_start_next = 1'b1;
              end
            end
          end
          PH_QUAL: begin
            if (in_byte == CH_LF) begin
              line_start_next = 1'b1;
              if (qual_len >= seq_len) begin
                n = 2'd1;
                if (lens_equal) begin
                  k0 = K_END; phase_next = PH_NEXTHDR;
                end else begin
                  k0 = K_ERR; e0 = E_QUAL_LEN; stuck_next = 1'b1;
                end
              end
            end else begin
              qual_len_next   = qual_inc;
              line_start_next = 1'b0;
              n = 2'd1; k0 = K_QUAL; b0 = in_byte;
            end
          end
          PH_NEXTHDR: begin
            n = 2'd1;
            if (in_byte == CH_AT) begin
              phase_next      = PH_HEADER;
              seq_len_next    = '0;
              qual_len_next   = '0;
              line_start_next = 1'b0;
              k0 = K_HDR; b0 = in_byte;
            end else begin
              k0 = K_ERR; e0 = E_BADHDR; stuck_next = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Pack results; the second one only occurs as a header '>' after a record end
  always_comb begin
    res.count    = n;
    res.r0.kind  = k0;
    res.r0.data  = b0;
    res.r0.err   = e0;
    res.r0.fastq = fastq_next;
    res.r0.last  = (n == 2'd1);
    res.r1.kind  = k1;
    res.r1.data  = CH_GT;
    res.r1.err   = E_NONE;
    res.r1.fastq = fastq_next;
    res.r1.last  = 1'b1;
  end

  // Advance parser state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      fastq      <= 1'b0;
      line_start <= 1'b1;
      seq_len    <= '0;
      qual_len   <= '0;
      stuck      <= 1'b0;
    end else if (in_take) begin
      phase      <= phase_next;
      fastq      <= fastq_next;
      line_start <= line_start_next;
      seq_len    <= seq_len_next;
      qual_len   <= qual_len_next;
      stuck      <= stuck_next;
    end
  end

endmodule

// ===== hdl/fasta_fastq_record_deframer_top.sv =====
// A result is written into the result queue when the item that causes it is accepted.
// Throughput: one item per cycle while s_axis_tready is high; a FASTA record boundary
// yields two results, which leave one after the other through a four-entry result queue.
// s_axis_tready is high while the queue holds two or fewer results.
// Reset (rst, synchronous, active high) empties the queue and returns the parser
// to the start phase, awaiting the format byte.
// Top level of the FASTA/FASTQ record deframer; depends on fqd_pkg, fqd_parser
// and the assertion macros header.
`include "fasta_fastq_record_deframer_top_macros.svh"

module fasta_fastq_record_deframer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [9:8] error_code, [15:10] zero
  output logic [3:0]  m_axis_tuser,   // [2:0] out_kind, [3] record_format
  output logic        m_axis_tlast    // last_result
);
  import fqd_pkg::*;

  logic         in_take;
  logic         out_take;
  result_pair_t res;

  result_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]    count, count_next;
  result_t              head;

  assign s_axis_tready = (count <= QCNT_W'(QDEPTH - 2));
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign out_take      = m_axis_tvalid && m_axis_tready;

  fqd_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .in_take       (in_take),
    .in_byte       (s_axis_tdata),
    .end_of_stream (s_axis_tlast),
    .res           (res)
  );

  // Write new results into the queue
  always_ff @(posedge clk) begin
    if (in_take && res.count != 2'd0) begin
      q_mem[wr_ptr] <= res.r0;
      if (res.count == 2'd2) begin
        q_mem[wr_ptr + 1'b1] <= res.r1;
      end
    end
  end

  assign count_next = count
                      + (in_take ? QCNT_W'(res.count) : '0)
                      - QCNT_W'(out_take);

  // Advance queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_take) begin
        wr_ptr <= wr_ptr + QPTR_W'(res.count);
      end
      if (out_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  // Present the oldest result
  assign head          = q_mem[rd_ptr];
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = {6'b0, head.err, head.data};
  assign m_axis_tuser  = {head.fastq, head.kind};
  assign m_axis_tlast  = head.last;

  `FQD_ASSERT_ALWAYS(a_count_bound, count <= QCNT_W'(QDEPTH))
  `FQD_ASSERT_FELL(a_ready_after_reset, rst, s_axis_tready && !m_axis_tvalid)
  `FQD_ASSERT_IMPLIES(a_nochar_zero, m_axis_tvalid && (head.kind == K_END || head.kind == K_ERR),
                      head.data == 8'h00)
  `FQD_ASSERT_IMPLIES(a_err_only_on_error, m_axis_tvalid && head.kind != K_ERR,
                      head.err == E_NONE)

endmodule

// ===== tb/deframer_shadow_pkg.sv =====
// Shadow of the FASTA/FASTQ deframer: tracks the parse state of every accepted
// item and keeps the results that must leave the block, oldest first.
// Depends on fqd_pkg for the phase, kind and error codes and the result layout.
package deframer_shadow_pkg;
  import fqd_pkg::*;

  class deframer_shadow;
    phase_t phase;
    bit fastq;
    bit line_start;
    bit stuck;
    logic [LENGTH_BITS-1:0] seq_len;
    logic [LENGTH_BITS-1:0] qual_len;
    result_t due_results[$];
    int unsigned mismatches;

    function new();
      phase = PH_START;
      fastq = 1'b0;
      line_start = 1'b1;
      stuck = 1'b0;
      seq_len = '0;
      qual_len = '0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    // Queue one result, stamped with the format in force
    function void emit(kind_t kind, logic [7:0] ch, err_t err);
      result_t r;
      r.kind = kind;
      r.data = ch;
      r.err = err;
      r.fastq = fastq;
      r.last = 1'b0;
      due_results.push_back(r);
    endfunction

    // Report an error once; everything after it is silent
    function void flag_error(err_t err);
      stuck = 1'b1;
      emit(K_ERR, 8'h00, err);
    endfunction

    function void close_fastq_record();
      if (qual_len == seq_len) begin
        phase = PH_NEXTHDR;
        emit(K_END, 8'h00, E_NONE);
      end else begin
        flag_error(E_QUAL_LEN);
      end
    endfunction

    function void open_record(logic [7:0] marker);
      phase = PH_HEADER;
      seq_len = '0;
      qual_len = '0;
      line_start = 1'b0;
      emit(K_HDR, marker, E_NONE);
    endfunction

    // Advance the parse by one accepted item
    function void parse_byte(logic [7:0] b, logic eos);
      int unsigned first_new;
      result_t tail;
      if (stuck || phase == PH_DONE) return;
      first_new = due_results.size();
      if (eos) begin
        case (phase)
          PH_START: flag_error(E_FORMAT);
          PH_HEADER, PH_SEQ, PH_PLUS, PH_QUAL: begin
            if (fastq) close_fastq_record();
            else emit(K_END, 8'h00, E_NONE);
          end
          default: ;
        endcase
        phase = PH_DONE;
      end else begin
        case (phase)
          PH_START: begin
            if (b == CH_GT || b == CH_AT) begin
              fastq = (b == CH_AT);
              open_record(b);
            end else begin
              flag_error(E_FORMAT);
            end
          end
          PH_HEADER: begin
            if (b == CH_LF) begin
              phase = PH_SEQ;
              line_start = 1'b1;
            end else begin
              emit(K_HDR, b, E_NONE);
            end
          end
          PH_SEQ: begin
            if (b == CH_LF) begin
              line_start = 1'b1;
            end else if (line_start && !fastq && b == CH_GT) begin
              // FASTA record boundary: close the old one, open the new one
              emit(K_END, 8'h00, E_NONE);
              open_record(b);
            end else if (line_start && fastq && b == CH_PLUS) begin
              phase = PH_PLUS;
              line_start = 1'b0;
            end else begin
              if (seq_len != LEN_MAX) seq_len = seq_len + 1'b1;
              line_start = 1'b0;
              emit(K_BASE, b, E_NONE);
            end
          end
          PH_PLUS: begin
            if (b == CH_LF) begin
              if (seq_len == '0) begin
                phase = PH_NEXTHDR;
                emit(K_END, 8'h00, E_NONE);
              end else begin
                phase = PH_QUAL;
                line_start = 1'b1;
              end
            end
          end
          PH_QUAL: begin
            if (b == CH_LF) begin
              line_start = 1'b1;
              if (qual_len >= seq_len) close_fastq_record();
            end else begin
              if (qual_len != LEN_MAX) qual_len = qual_len + 1'b1;
              line_start = 1'b0;
              emit(K_QUAL, b, E_NONE);
            end
          end
          PH_NEXTHDR: begin
            if (b == CH_AT) open_record(b);
            else flag_error(E_BADHDR);
          end
          default: ;
        endcase
      end
      // Mark the final result of this item
      if (due_results.size() > first_new) begin
        tail = due_results.pop_back();
        tail.last = 1'b1;
        due_results.push_back(tail);
      end
    endfunction

    function void check_field(string what, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %02h, actual %02h", $time, what, want, got);
        mismatches++;
      end
    endfunction

    // Compare one accepted result with the oldest one due
    function void match_result(logic [15:0] data, logic [3:0] user, logic last);
      result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result with none due, expected nothing, actual kind %0d byte %02h",
                 $time, user[2:0], data[7:0]);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      check_field("out_kind", 8'(want.kind), 8'(user[2:0]));
      check_field("out_byte", want.data, data[7:0]);
      check_field("error_code", 8'(want.err), 8'(data[9:8]));
      check_field("record_format", 8'(want.fastq), 8'(user[3]));
      check_field("last_result", 8'(want.last), 8'(last));
      check_field("tdata padding", 8'h00, 8'(data[15:10]));
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
// Stream testbench of fasta_fastq_record_deframer_top: one FASTA or FASTQ text
// stream with random records, idles on both sides and a long output hold-off.
// Depends on fqd_pkg and deframer_shadow_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fqd_pkg::*;
  import deframer_shadow_pkg::*;

  localparam int unsigned RANDOM_TARGET = 1930;
  localparam int unsigned IDLE_PCT = 20;
  localparam int unsigned SEND_CALM_AT = 1000;
  localparam int unsigned SEND_CALM_LEN = 300;
  localparam int unsigned HOLD_AT = 600;
  localparam int unsigned HOLD_LEN = 250;
  localparam int unsigned TAKE_CALM_AT = 1400;
  localparam int unsigned TAKE_CALM_LEN = 600;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [3:0] m_axis_tuser;
  logic m_axis_tlast;

  typedef struct packed {
    logic eos;
    logic [7:0] ch;
  } text_item_t;

  text_item_t text_q[$];
  deframer_shadow shadow;
  bit fastq_run;
  int unsigned cycle_count = 0;

  fasta_fastq_record_deframer_top u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Track accepted items and results on both handshakes
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) shadow.parse_byte(s_axis_tdata, s_axis_tlast);
    if (!rst && m_axis_tvalid && m_axis_tready)
      shadow.match_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Drive result ready: random stalls, one long hold-off, one calm stretch
  initial begin : take_results
    int unsigned n;
    n = 0;
    forever begin
      @(posedge clk);
      if (n >= HOLD_AT && n < HOLD_AT + HOLD_LEN) m_axis_tready <= 1'b0;
      else if (n >= TAKE_CALM_AT && n < TAKE_CALM_AT + TAKE_CALM_LEN) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
      n++;
    end
  end

  task automatic push_item(logic eos, logic [7:0] ch);
    text_item_t it;
    it.eos = eos;
    it.ch = ch;
    text_q.push_back(it);
  endtask

  task automatic push_byte(logic [7:0] ch);
    push_item(1'b0, ch);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // Any byte but a newline and the given one, bases half of the time
  function automatic logic [7:0] pick_byte(logic [7:0] forbid);
    logic [7:0] b;
    do begin
      if ($urandom_range(1)) begin
        case ($urandom_range(3))
          0: b = "A";
          1: b = "C";
          2: b = "G";
          default: b = "T";
        endcase
      end else begin
        b = 8'($urandom_range(255));
      end
    end while (b == CH_LF || b == forbid);
    return b;
  endfunction

  task automatic push_line(int unsigned len, logic [7:0] forbid_first);
    for (int i = 0; i < len; i++) push_byte(pick_byte(i == 0 ? forbid_first : CH_LF));
    push_byte(CH_LF);
  endtask

  // One well-formed record in the chosen format
  task automatic add_record();
    int unsigned n_lines;
    int unsigned seq_total;
    int unsigned left;
    int unsigned chunk;
    seq_total = 0;
    push_byte(fastq_run ? CH_AT : CH_GT);
    push_line($urandom_range(8), CH_LF);
    n_lines = $urandom_range(3);
    if (!fastq_run) begin
      repeat (n_lines) push_line($urandom_range(12), CH_GT);
    end else begin
      repeat (n_lines) begin
        chunk = $urandom_range(12);
        seq_total += chunk;
        push_line(chunk, CH_PLUS);
      end
      push_byte(CH_PLUS);
      push_line($urandom_range(4), CH_LF);
      // Split the quality string over lines, empty ones included
      left = seq_total;
      while (left != 0) begin
        chunk = $urandom_range(left);
        left -= chunk;
        push_line(chunk, CH_LF);
      end
    end
  endtask

  // Close the stream cleanly, mid-record, or with a broken record
  task automatic add_ending();
    case ($urandom_range(3))
      0: ;
      1: begin
        push_byte(fastq_run ? CH_AT : CH_GT);
        push_line(3, CH_LF);
        repeat ($urandom_range(4)) push_byte(pick_byte(fastq_run ? CH_PLUS : CH_GT));
      end
      2: begin
        if (fastq_run) begin
          push_byte($urandom_range(1) ? CH_LF : pick_byte(CH_AT));
        end else begin
          push_byte(CH_GT);
          push_byte(pick_byte(CH_LF));
        end
      end
      default: begin
        if (fastq_run) begin
          push_text("@\nAC\n+\n");
          push_line(3, CH_LF);
        end else begin
          push_line(5, CH_GT);
        end
      end
    endcase
    push_item(1'b1, 8'($urandom_range(255)));
    // Trailing items the block must ignore
    repeat (8) push_item(1'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  // Offer one item and hold it until accepted
  task automatic send_item(text_item_t it, int idx);
    bit calm;
    calm = (idx >= SEND_CALM_AT && idx < SEND_CALM_AT + SEND_CALM_LEN);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= it.ch;
    s_axis_tlast <= it.eos;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  initial begin : main_flow
    shadow = new();
    fastq_run = 1'($urandom_range(1));

    // Directed opening: byte extremes, boundaries, empty lines, markers as data
    if (!fastq_run) begin
      push_byte(CH_GT);
      push_byte(8'hFF);
      push_byte(8'h00);
      push_text("\nA>");
      push_byte(8'hFF);
      push_byte(8'h00);
      push_text("\n\n>h\n+@\n");
    end else begin
      push_byte(CH_AT);
      push_byte(8'hFF);
      push_byte(8'h00);
      push_text("\n+x\n@\n@+");
      push_byte(8'hFF);
      push_text("\n+\n\n");
      push_byte(8'h00);
      push_text("\n");
      push_byte(8'hFF);
      push_text("+\n");
    end
    while (text_q.size() < RANDOM_TARGET) add_record();
    add_ending();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (text_q[i]) send_item(text_q[i], i);
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
